[hw/rtl/lbp_pkg.sv]
// Shared types, sizes and helpers for the LED blink and PWM dimming controller.
`timescale 1ns / 1ps

package lbp_pkg;

  localparam int NUM_LEDS  = 8;
  localparam int PWM_STEPS = 8;

  localparam int IdxW  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int DutyW = $clog2(PWM_STEPS);

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_BLINK  = 2'd1,
    FUNC_BRIGHT = 2'd2
  } lbp_func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } lbp_state_e;

  // One command item as held while it is being worked on.
  typedef struct packed {
    lbp_func_e   func;
    logic [2:0]  led_index;
    logic [15:0] on_ticks;
    logic [15:0] off_ticks;
    logic [7:0]  repeat_count;
    logic [7:0]  brightness;
  } lbp_cmd_t;

  // Per-LED entry of the state memory.
  typedef struct packed {
    logic [15:0]      period_len;
    logic [15:0]      on_limit;
    logic [15:0]      tick_count;
    logic [7:0]       cycles_left;
    logic [DutyW-1:0] duty_level;
  } lbp_entry_t;

  // Per-LED result bits that the update unit hands back to the sequencer.
  typedef struct packed {
    logic lit;
    logic pwm_on;
    logic active;
    logic repeat_on;
  } lbp_flags_t;

  // Remainder of a byte by PWM_STEPS as a short restoring reduction.
  function automatic logic [DutyW-1:0] duty_mod(input logic [7:0] value);
    logic [11:0] rem;
    rem = {4'b0, value};
    for (int k = 7; k >= 0; k--) begin
      if (rem >= 12'(PWM_STEPS << k)) begin
        rem = rem - 12'(PWM_STEPS << k);
      end
    end
    return DutyW'(rem);
  endfunction

endpackage

[hw/rtl/led_blink_pwm_controller.sv]
// LED blink and PWM dimming controller for NUM_LEDS LEDs. Each input item is a
// command: a tick (tuser 0) advances the global PWM phase and every LED's blink
// counter and returns the new LED drive pattern; set blink (tuser 1) and set
// brightness (tuser 2) update one LED and return the last drive pattern again.
// Every command yields exactly one output item. Per-LED state sits in a small
// memory that is read, updated and written back one LED per cycle; a tick walks
// all NUM_LEDS entries, a set command only its own LED, and then the result
// passes the drain and finish states into the output register. An unused code
// or an out-of-range LED goes straight to the finish state. The next item is
// taken as soon as the result has moved into the output register, even if that
// result is still waiting to be taken. The state memory needs no clearing pass
// after reset. enable_mask is written through cfg_we_i and cfg_wdata_i; the user
// must write it only while the block is idle, which the block does not enforce.
// It resets to all ones.
`timescale 1ns / 1ps

module led_blink_pwm_controller
  import lbp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] led_index, [18:3] on_ticks, [34:19] off_ticks, [42:35] repeat_count,
  // [50:43] brightness, [55:51] zero
  input  logic [55:0] s_axis_tdata,
  // [1:0] func
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] led_drive
  output logic [7:0]  m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  lbp_state_e          state_q, state_d;
  lbp_cmd_t            cmd_q;
  logic [IdxW-1:0]     idx_q;
  logic                rd_pend_q;
  logic [IdxW-1:0]     rd_idx_q;
  logic [NUM_LEDS-1:0] active_q;
  logic [NUM_LEDS-1:0] repeat_q;
  logic [DutyW-1:0]    phase_q;
  logic [NUM_LEDS-1:0] blink_acc_q;
  logic [NUM_LEDS-1:0] pwm_acc_q;
  logic [NUM_LEDS-1:0] drive_hold_q;
  logic [7:0]          enable_q;
  logic                out_valid_q;
  logic [7:0]          out_data_q;

  logic                in_fire;
  lbp_func_e           in_func;
  logic [2:0]          in_led;
  logic                in_led_ok;
  logic                last_issue;
  logic                mem_rd_en;
  logic                finish_go;
  logic [DutyW-1:0]    phase_inc;
  logic [NUM_LEDS-1:0] drive_new;
  lbp_entry_t          rd_entry;
  lbp_entry_t          wr_entry;
  lbp_flags_t          flags;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign in_func   = lbp_func_e'(s_axis_tuser);
  assign in_led    = s_axis_tdata[2:0];
  assign in_led_ok = {1'b0, in_led} < 4'(NUM_LEDS);
  assign last_issue = (cmd_q.func != FUNC_TICK) || (idx_q == IdxW'(NUM_LEDS - 1));
  assign phase_inc = (phase_q == DutyW'(PWM_STEPS - 1)) ? '0 : phase_q + DutyW'(1);
  assign drive_new = blink_acc_q & pwm_acc_q & enable_q[NUM_LEDS-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_func == FUNC_TICK) begin
            state_d = ST_WALK;
          end else if ((in_func == FUNC_BLINK || in_func == FUNC_BRIGHT) && in_led_ok) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_WALK: begin
        if (last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    mem_rd_en     = 1'b0;
    finish_go     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_WALK: begin
        mem_rd_en = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_FINISH: begin
        finish_go = !out_valid_q || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rd_pend_q    <= 1'b0;
      active_q     <= '0;
      repeat_q     <= '0;
      phase_q      <= '0;
      drive_hold_q <= '0;
      enable_q     <= 8'hFF;
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= mem_rd_en;
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      if (in_fire && in_func == FUNC_TICK) begin
        phase_q <= phase_inc;
      end
      if (rd_pend_q) begin
        active_q[rd_idx_q] <= flags.active;
        repeat_q[rd_idx_q] <= flags.repeat_on;
      end
      if (finish_go) begin
        out_valid_q <= 1'b1;
        if (cmd_q.func == FUNC_TICK) begin
          drive_hold_q <= drive_new;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Command, walk index and per-tick accumulators.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_q;
    if (in_fire) begin
      cmd_q.func         <= in_func;
      cmd_q.led_index    <= in_led;
      cmd_q.on_ticks     <= s_axis_tdata[18:3];
      cmd_q.off_ticks    <= s_axis_tdata[34:19];
      cmd_q.repeat_count <= s_axis_tdata[42:35];
      cmd_q.brightness   <= s_axis_tdata[50:43];
      idx_q              <= (in_func == FUNC_TICK) ? '0 : IdxW'(in_led);
      blink_acc_q        <= '0;
      pwm_acc_q          <= '0;
    end else begin
      if (mem_rd_en && !last_issue) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (rd_pend_q) begin
        blink_acc_q[rd_idx_q] <= flags.lit;
        pwm_acc_q[rd_idx_q]   <= flags.pwm_on;
      end
    end
    if (finish_go) begin
      out_data_q <= (cmd_q.func == FUNC_TICK) ? 8'(drive_new) : 8'(drive_hold_q);
    end
  end

  lbp_state_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_entry),
    .wr_en_i   (rd_pend_q),
    .wr_addr_i (rd_idx_q),
    .wr_data_i (wr_entry)
  );

  lbp_led_unit u_unit (
    .cmd_i    (cmd_q),
    .entry_i  (rd_entry),
    .active_i (active_q[rd_idx_q]),
    .repeat_i (repeat_q[rd_idx_q]),
    .phase_i  (phase_q),
    .entry_o  (wr_entry),
    .flags_o  (flags)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[hw/rtl/lbp_state_mem.sv]
// Per-LED state memory with a registered read and per-entry valid bits.
`timescale 1ns / 1ps

module lbp_state_mem
  import lbp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output lbp_entry_t      rd_data_o,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  lbp_entry_t      wr_data_i
);

  lbp_entry_t          mem_q [NUM_LEDS];
  logic [NUM_LEDS-1:0] valid_q;
  lbp_entry_t          rd_data_q;
  logic                rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // An entry never written reads as all zeros, which is its reset value.
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

[hw/rtl/lbp_led_unit.sv]
// Update of one LED entry for a tick, a blink setting or a brightness setting.
`timescale 1ns / 1ps

module lbp_led_unit
  import lbp_pkg::*;
(
  input  lbp_cmd_t         cmd_i,
  input  lbp_entry_t       entry_i,
  input  logic             active_i,
  input  logic             repeat_i,
  input  logic [DutyW-1:0] phase_i,
  output lbp_entry_t       entry_o,
  output lbp_flags_t       flags_o
);

  logic [15:0] count_inc;
  logic [7:0]  cycles_next;

  assign count_inc   = entry_i.tick_count + 16'd1;
  assign cycles_next = repeat_i ? entry_i.cycles_left : entry_i.cycles_left - 8'd1;

  always_comb begin
    entry_o           = entry_i;
    flags_o.lit       = 1'b0;
    flags_o.pwm_on    = entry_i.duty_level > phase_i;
    flags_o.active    = active_i;
    flags_o.repeat_on = repeat_i;
    case (cmd_i.func)
      FUNC_TICK: begin
        if (active_i && (entry_i.cycles_left != 8'd0)) begin
          flags_o.lit        = count_inc <= entry_i.on_limit;
          entry_o.tick_count = count_inc;
          // End of one blink cycle: wrap and maybe use up one repetition.
          if (count_inc == entry_i.period_len) begin
            entry_o.tick_count  = 16'd0;
            entry_o.cycles_left = cycles_next;
            if (cycles_next != 8'd0) begin
              flags_o.lit = 1'b1;
            end else begin
              flags_o.lit    = 1'b0;
              flags_o.active = 1'b0;
            end
          end
        end
      end
      FUNC_BLINK: begin
        entry_o.period_len  = cmd_i.on_ticks + cmd_i.off_ticks;
        entry_o.on_limit    = cmd_i.on_ticks;
        entry_o.cycles_left = (cmd_i.repeat_count == 8'd0) ? 8'd1 : cmd_i.repeat_count;
        flags_o.active      = 1'b1;
        flags_o.repeat_on   = cmd_i.repeat_count == 8'd0;
      end
      FUNC_BRIGHT: begin
        entry_o.duty_level = duty_mod(cmd_i.brightness);
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/lbp_checker.sv]
// Port-level checks on the LED blink and PWM controller, bound to the top level.
`timescale 1ns / 1ps

module lbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  // A waiting output item stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item dropped or changed while stalled");

  // Only one item is worked on at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again while an item is in work");

  // A result never appears in the cycle right after its item is taken.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // Leaving reset, no output item is offered.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind led_blink_pwm_controller lbp_checker u_lbp_checker (.*);
